FILE: rtl/raa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Region arena allocator package
// Shared constants, codes and the fill memory request type.
// ----------------------------------------------------------------------------
package raa_pkg;

  localparam int MaxRegions = 16;
  localparam int RegionIdxW = (MaxRegions > 1) ? $clog2(MaxRegions) : 1;
  localparam int FillW      = 16;
  localparam int RegionOutW = 8;

  localparam logic [1:0] ActAlloc   = 2'd0;
  localparam logic [1:0] ActRealloc = 2'd1;
  localparam logic [1:0] ActReset   = 2'd2;

  localparam logic [1:0] StatusOk     = 2'd0;
  localparam logic [1:0] StatusTooBig = 2'd1;
  localparam logic [1:0] StatusNoRoom = 2'd2;

  localparam logic [FillW-1:0] CapacityReset = FillW'(1024);

  // One write port and one read port into the fill memory.
  typedef struct packed {
    logic                  we;
    logic [RegionIdxW-1:0] waddr;
    logic [FillW-1:0]      wdata;
    logic                  re;
    logic [RegionIdxW-1:0] raddr;
  } ram_req_t;

endpackage
`default_nettype wire

FILE: rtl/raa_fill_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Region fill memory
// One write port and one registered read port holding the fill of each region.
// ----------------------------------------------------------------------------
module raa_fill_ram (
  input  wire                             clk_i,
  input  wire raa_pkg::ram_req_t          req_i,
  output logic [raa_pkg::FillW-1:0]       rdata_o
);

  logic [raa_pkg::FillW-1:0] mem [raa_pkg::MaxRegions];
  logic [raa_pkg::FillW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

FILE: rtl/region_arena_allocator.sv
`default_nettype none
// A reset, an unused action, an oversized request or a reallocation that does
// not grow gives its result in the cycle after start. A first-fit walk reads
// one region fill per cycle from the fill memory, busy staying high meanwhile.
// A new word may be started in the cycle the result strobe is high.
// Reset clears the capacity to 1024 and marks every fill as zero at once.
// ----------------------------------------------------------------------------
// Region arena allocator
// First-fit bump allocator over a row of equal regions, one fill per region.
// ----------------------------------------------------------------------------
module region_arena_allocator (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_we_i,
  input  wire  [15:0]                      cfg_wdata_i,
  input  wire                              start,
  output logic                             busy,
  input  wire  [1:0]                       action_i,
  input  wire  [15:0]                      request_size_i,
  input  wire  [7:0]                       old_region_i,
  input  wire  [15:0]                      old_offset_i,
  input  wire  [15:0]                      prior_size_i,
  output logic                             done_o,
  output logic [7:0]                       region_index_o,
  output logic [15:0]                      byte_offset_o,
  output logic                             copy_needed_o,
  output logic [1:0]                       status_o
);

  localparam int IdxW = raa_pkg::RegionIdxW;
  localparam int FW   = raa_pkg::FillW;

  localparam logic StateIdle = 1'b0;
  localparam logic StateWalk = 1'b1;

  localparam logic [IdxW-1:0] LastIdx = IdxW'(raa_pkg::MaxRegions - 1);

  logic                    state_q, state_d;
  logic [IdxW-1:0]         idx_q, idx_d;
  logic [FW-1:0]           req_q, req_d;
  logic                    copy_q, copy_d;
  logic [FW-1:0]           cap_q;
  logic [raa_pkg::MaxRegions-1:0] valid_q, valid_d;

  logic                    done_d;
  logic [7:0]              region_d;
  logic [15:0]             offset_d;
  logic                    copy_out_d;
  logic [1:0]              status_d;

  raa_pkg::ram_req_t       ram_req;
  logic [FW-1:0]           rdata;
  logic [FW-1:0]           fill;
  logic [FW:0]             sum;
  logic                    fits;
  logic                    accept;
  logic                    grow;

  raa_fill_ram u_fill_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (rdata)
  );

  assign accept = start && !busy;
  assign busy   = (state_q == StateWalk);
  assign grow   = (action_i == raa_pkg::ActAlloc) ||
                  ((action_i == raa_pkg::ActRealloc) && (request_size_i > prior_size_i));

  // A region never written since the last clear reads as empty.
  assign fill = valid_q[idx_q] ? rdata : '0;
  assign sum  = {1'b0, fill} + {1'b0, req_q};
  assign fits = (sum <= {1'b0, cap_q});

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    req_d      = req_q;
    copy_d     = copy_q;
    valid_d    = valid_q;
    done_d     = 1'b0;
    region_d   = '0;
    offset_d   = '0;
    copy_out_d = 1'b0;
    status_d   = raa_pkg::StatusOk;
    ram_req    = '0;

    case (state_q)
      StateIdle: begin
        if (accept) begin
          if (grow) begin
            if (request_size_i > cap_q) begin
              done_d   = 1'b1;
              status_d = raa_pkg::StatusTooBig;
            end else begin
              state_d       = StateWalk;
              idx_d         = '0;
              req_d         = request_size_i;
              copy_d        = (action_i == raa_pkg::ActRealloc);
              ram_req.re    = 1'b1;
              ram_req.raddr = '0;
            end
          end else if (action_i == raa_pkg::ActRealloc) begin
            done_d   = 1'b1;
            region_d = old_region_i;
            offset_d = old_offset_i;
          end else begin
            done_d = 1'b1;
            if (action_i == raa_pkg::ActReset) begin
              valid_d = '0;
            end
          end
        end
      end
      StateWalk: begin
        if (fits) begin
          state_d          = StateIdle;
          done_d           = 1'b1;
          region_d         = 8'(idx_q);
          offset_d         = fill;
          copy_out_d       = copy_q;
          ram_req.we       = 1'b1;
          ram_req.waddr    = idx_q;
          ram_req.wdata    = sum[FW-1:0];
          valid_d[idx_q]   = 1'b1;
        end else if (idx_q == LastIdx) begin
          state_d  = StateIdle;
          done_d   = 1'b1;
          status_d = raa_pkg::StatusNoRoom;
        end else begin
          idx_d         = idx_q + 1'b1;
          ram_req.re    = 1'b1;
          ram_req.raddr = idx_q + 1'b1;
        end
      end
      default: begin
        state_d = StateIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StateIdle;
      idx_q   <= '0;
      valid_q <= '0;
      cap_q   <= raa_pkg::CapacityReset;
      done_o  <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      valid_q <= valid_d;
      done_o  <= done_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q          <= req_d;
    copy_q         <= copy_d;
    region_index_o <= region_d;
    byte_offset_o  <= offset_d;
    copy_needed_o  <= copy_out_d;
    status_o       <= status_d;
  end

`ifndef SYNTHESIS
  // The result of a walk appears only once the sequencer has returned to idle.
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result strobe while walking");

  // A fitting region ends the walk with a strobe in the next cycle.
  a_fit_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StateWalk && fits) |=> (done_o && status_o == raa_pkg::StatusOk))
    else $error("fitting region gave no result");

  // Error results carry no place and no copy request.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != raa_pkg::StatusOk) |->
      (region_index_o == '0 && byte_offset_o == '0 && !copy_needed_o))
    else $error("error result carries a place");

  // A copy is only requested on a successful move.
  a_copy_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && copy_needed_o) |-> (status_o == raa_pkg::StatusOk))
    else $error("copy flagged on failed request");
`endif

endmodule
`default_nettype wire

FILE: tb/tb_region_arena_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Region arena allocator testbench
// Drives allocate, reallocate, clear and unused-action words through the start/busy port
// in random bursts, with capacity writes between them. A behavioural model of the per-region
// fill levels predicts each result, and the result strobe is checked field by field against it.
// ----------------------------------------------------------------------------
module tb_region_arena_allocator;

  localparam logic [1:0] ActUnused     = 2'd3;
  localparam int         WatchdogLimit = 1000;

  typedef struct packed {
    logic        is_cfg;
    logic [15:0] cfg_value;
    logic [1:0]  action;
    logic [15:0] request_size;
    logic [7:0]  old_region;
    logic [15:0] old_offset;
    logic [15:0] prior_size;
  } alloc_word_t;

  typedef struct packed {
    logic [7:0]  region_index;
    logic [15:0] byte_offset;
    logic        copy_needed;
    logic [1:0]  status;
  } grant_t;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        cfg_we_i       = 1'b0;
  logic [15:0] cfg_wdata_i    = '0;
  logic        start          = 1'b0;
  logic [1:0]  action_i       = '0;
  logic [15:0] request_size_i = '0;
  logic [7:0]  old_region_i   = '0;
  logic [15:0] old_offset_i   = '0;
  logic [15:0] prior_size_i   = '0;
  logic        busy;
  logic        done_o;
  logic [7:0]  region_index_o;
  logic [15:0] byte_offset_o;
  logic        copy_needed_o;
  logic [1:0]  status_o;

  alloc_word_t pending_words[$];
  grant_t      expected_grants[$];

  // Model of the allocator state.
  logic [raa_pkg::FillW-1:0] fill_model [raa_pkg::MaxRegions];
  logic [15:0]               capacity_model = raa_pkg::CapacityReset;

  int unsigned mismatches    = 0;
  int unsigned words_offered = 0;
  int unsigned words_taken   = 0;
  int unsigned burst_left    = 1;
  int unsigned gap_left      = 0;
  int unsigned quiet_cycles  = 0;
  int unsigned stall_cycles  = 0;

  region_arena_allocator uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .start          (start),
    .busy           (busy),
    .action_i       (action_i),
    .request_size_i (request_size_i),
    .old_region_i   (old_region_i),
    .old_offset_i   (old_offset_i),
    .prior_size_i   (prior_size_i),
    .done_o         (done_o),
    .region_index_o (region_index_o),
    .byte_offset_o  (byte_offset_o),
    .copy_needed_o  (copy_needed_o),
    .status_o       (status_o)
  );

  always #4 clk_i = ~clk_i;

  // First region whose fill plus the size still fits takes the block.
  function automatic logic [1:0] first_fit(input logic [15:0] size,
                                           output logic [7:0] slot,
                                           output logic [15:0] offset);
    slot   = '0;
    offset = '0;
    if (size > capacity_model) return raa_pkg::StatusTooBig;
    for (int i = 0; i < raa_pkg::MaxRegions; i++) begin
      if (int'(fill_model[i]) + int'(size) <= int'(capacity_model)) begin
        slot          = 8'(i);
        offset        = fill_model[i];
        fill_model[i] = fill_model[i] + size;
        return raa_pkg::StatusOk;
      end
    end
    return raa_pkg::StatusNoRoom;
  endfunction

  function automatic grant_t predict_grant(input alloc_word_t w);
    grant_t      g;
    logic [1:0]  st;
    logic [7:0]  slot;
    logic [15:0] offset;
    g = '0;
    case (w.action)
      raa_pkg::ActAlloc: begin
        st             = first_fit(w.request_size, slot, offset);
        g.region_index = slot;
        g.byte_offset  = offset;
        g.status       = st;
      end
      raa_pkg::ActRealloc: begin
        if (w.request_size <= w.prior_size) begin
          g.region_index = w.old_region;
          g.byte_offset  = w.old_offset;
        end else begin
          st             = first_fit(w.request_size, slot, offset);
          g.region_index = slot;
          g.byte_offset  = offset;
          g.copy_needed  = (st == raa_pkg::StatusOk);
          g.status       = st;
        end
      end
      raa_pkg::ActReset: begin
        foreach (fill_model[i]) fill_model[i] = '0;
      end
      default: ;
    endcase
    return g;
  endfunction

  task automatic check_field(input string field, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      mismatches++;
    end
  endtask

  // Driver: offers words in bursts; a capacity write waits until the block is idle.
  always @(negedge clk_i) begin
    alloc_word_t head;
    logic        nxt_start;
    logic        nxt_cfg_we;
    nxt_start  = start;
    nxt_cfg_we = 1'b0;
    if (expected_grants.size() == 0 && !start && !busy) quiet_cycles++;
    else quiet_cycles = 0;
    if (start && words_taken == words_offered) nxt_start = 1'b0;
    if (rst_ni && !nxt_start && pending_words.size() > 0) begin
      if (gap_left > 0) begin
        gap_left--;
      end else begin
        head = pending_words[0];
        if (!head.is_cfg) begin
          void'(pending_words.pop_front());
          action_i       <= head.action;
          request_size_i <= head.request_size;
          old_region_i   <= head.old_region;
          old_offset_i   <= head.old_offset;
          prior_size_i   <= head.prior_size;
          nxt_start      = 1'b1;
          words_offered++;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 16);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
          end else begin
            burst_left--;
          end
        end else if (quiet_cycles >= 4) begin
          void'(pending_words.pop_front());
          cfg_wdata_i <= head.cfg_value;
          nxt_cfg_we  = 1'b1;
        end
      end
    end
    start    <= nxt_start;
    cfg_we_i <= nxt_cfg_we;
  end

  // Monitor: checks the result strobe first, since a new word may be taken at
  // the same edge, then predicts any word accepted at this edge.
  always @(posedge clk_i) begin
    grant_t      got;
    grant_t      want;
    alloc_word_t w;
    if (rst_ni) begin
      if (done_o) begin
        got = '{region_index_o, byte_offset_o, copy_needed_o, status_o};
        if (expected_grants.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, got);
          mismatches++;
        end else begin
          want = expected_grants.pop_front();
          check_field("region_index", want.region_index, got.region_index);
          check_field("byte_offset", want.byte_offset, got.byte_offset);
          check_field("copy_needed", want.copy_needed, got.copy_needed);
          check_field("status", want.status, got.status);
        end
      end
      if (start && !busy) begin
        w = '{1'b0, 16'd0, action_i, request_size_i, old_region_i, old_offset_i,
              prior_size_i};
        expected_grants.push_back(predict_grant(w));
        words_taken <= words_taken + 1;
      end
      if (cfg_we_i) capacity_model = cfg_wdata_i;
      if (done_o || (start && !busy) || cfg_we_i) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= WatchdogLimit) begin
          $display("%0t: no progress for %0d cycles", $time, WatchdogLimit);
          $display("== FAIL ==");
          $finish;
        end
      end
    end
  end

  task automatic queue_request(input logic [1:0] action, input logic [15:0] size,
                               input logic [7:0] old_region,
                               input logic [15:0] old_offset,
                               input logic [15:0] prior_size);
    pending_words.push_back('{1'b0, 16'd0, action, size, old_region, old_offset,
                              prior_size});
  endtask

  task automatic queue_capacity(input logic [15:0] value);
    pending_words.push_back('{1'b1, value, 2'd0, 16'd0, 8'd0, 16'd0, 16'd0});
  endtask

  // Mostly sizes that fit the capacity, so that regions fill up and spill over.
  task automatic queue_random_phase(input logic [15:0] cap, input int count);
    int unsigned pick;
    logic [1:0]  action;
    logic [15:0] size;
    logic [15:0] prior_size;
    queue_capacity(cap);
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) action = raa_pkg::ActReset;
      else if (pick < 7) action = ActUnused;
      else if (pick < 37) action = raa_pkg::ActRealloc;
      else action = raa_pkg::ActAlloc;
      case ($urandom_range(0, 9))
        0: size = 16'($urandom_range(0, 65535));
        1: size = (cap == 16'hFFFF) ? cap : cap + 16'd1;
        2, 3, 4, 5: size = 16'($urandom_range(0, (cap / 8 > 0) ? cap / 8 : 1));
        default: size = 16'($urandom_range(0, cap));
      endcase
      prior_size = $urandom_range(0, 1) ? 16'($urandom_range(size, 65535))
                                         : 16'($urandom_range(0, 65535));
      queue_request(action, size, 8'($urandom_range(0, 255)),
                    16'($urandom_range(0, 65535)), prior_size);
    end
  endtask

  initial begin
    logic [15:0] phase_caps [8];
    foreach (fill_model[i]) fill_model[i] = '0;

    // Directed part at the reset capacity of 1024.
    queue_request(raa_pkg::ActAlloc, 16'd0, 8'd0, 16'd0, 16'd0);
    queue_request(raa_pkg::ActAlloc, 16'd1024, 8'd0, 16'd0, 16'd0);
    queue_request(raa_pkg::ActAlloc, 16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF);
    queue_request(raa_pkg::ActRealloc, 16'd10, 8'hFF, 16'hFFFF, 16'd20);
    queue_request(raa_pkg::ActRealloc, 16'hFFFF, 8'hAA, 16'h5555, 16'hFFFF);
    queue_request(raa_pkg::ActRealloc, 16'd100, 8'd0, 16'd0, 16'd5);
    queue_request(raa_pkg::ActRealloc, 16'd2000, 8'd3, 16'd7, 16'd0);
    queue_request(ActUnused, 16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF);
    queue_request(raa_pkg::ActReset, 16'h5A5A, 8'h3C, 16'hA5A5, 16'h0F0F);

    // Smallest capacity: fill every region, then run out of room.
    queue_capacity(16'd1);
    for (int i = 0; i < raa_pkg::MaxRegions; i++) begin
      queue_request(raa_pkg::ActAlloc, 16'd1, 8'd0, 16'd0, 16'd0);
    end
    queue_request(raa_pkg::ActAlloc, 16'd1, 8'd0, 16'd0, 16'd0);
    queue_request(raa_pkg::ActAlloc, 16'd0, 8'd0, 16'd0, 16'd0);
    queue_request(raa_pkg::ActRealloc, 16'd1, 8'd4, 16'd9, 16'd0);

    // Largest capacity over regions that already hold a byte each.
    queue_capacity(16'hFFFF);
    queue_request(raa_pkg::ActAlloc, 16'hFFFF, 8'd0, 16'd0, 16'd0);
    queue_request(raa_pkg::ActAlloc, 16'hFFFE, 8'd0, 16'd0, 16'd0);

    phase_caps[0] = 16'd16;
    phase_caps[1] = 16'hFFFF;
    phase_caps[2] = 16'd1;
    phase_caps[3] = 16'($urandom_range(2, 65534));
    phase_caps[4] = 16'd200;
    phase_caps[5] = raa_pkg::CapacityReset;
    phase_caps[6] = 16'($urandom_range(1, 64));
    phase_caps[7] = 16'd40000;
    foreach (phase_caps[p]) queue_random_phase(phase_caps[p], 50);

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_words.size() > 0 || start || expected_grants.size() > 0)
      @(posedge clk_i);
    repeat (raa_pkg::MaxRegions + 8) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/raa_pkg.sv
rtl/raa_fill_ram.sv
rtl/region_arena_allocator.sv
tb/tb_region_arena_allocator.sv
